// ===== design/salu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salu_pkg
// Shared types and constants of the stack ALU: request and response
// payloads, operation and status codes, stack cell controls.
// ----------------------------------------------------------------------------
package salu_pkg;

    localparam int WORD_W              = 32;
    localparam int DEFAULT_STACK_DEPTH = 64;
    localparam int DIV_STEPS           = WORD_W;
    localparam int DEPTH_OUT_W         = 7;

    // operation codes
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_MUL  = 3'd4;
    localparam logic [2:0] OP_MOD  = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_DIVZERO  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_HALTED   = 3'd4;

    typedef struct packed {
        logic [2:0]               req_type;
        logic signed [WORD_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [WORD_W-1:0] top_value;
        logic [DEPTH_OUT_W-1:0]   stack_depth;
    } res_t;

    typedef struct packed {
        logic take_above;
        logic take_below;
    } cell_ctrl_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
        logic [WORD_W-1:0] remainder;
    } div_out_t;

endpackage

// ===== design/salu_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salu_cell
// One stack entry. Takes the word from above on a push (and, in the head cell,
// on a pop), from the entry below on a pop, and holds otherwise.
// ----------------------------------------------------------------------------
module salu_cell
    import salu_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [WORD_W-1:0] above,
    input  logic [WORD_W-1:0] below,
    output logic [WORD_W-1:0] value
);

    logic [WORD_W-1:0] value_reg;
    logic [WORD_W-1:0] value_next;

    always_comb
    begin
        priority if (ctrl.take_above)
        begin
            value_next = above;
        end
        else if (ctrl.take_below)
        begin
            value_next = below;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== design/salu_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salu_div
// Iterative signed divider, one quotient bit per cycle. Quotient and
// remainder truncate toward zero; the remainder follows the dividend's sign.
// ----------------------------------------------------------------------------
module salu_div
    import salu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output div_out_t          result
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              done_reg;
    logic              done_next;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] rem_next;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] quo_next;
    logic [WORD_W-1:0] dvs_reg;
    logic [WORD_W-1:0] dvs_next;
    logic              neg_q_reg;
    logic              neg_q_next;
    logic              neg_r_reg;
    logic              neg_r_next;

    logic [WORD_W:0]   rem_shift;
    logic [WORD_W:0]   diff;
    logic [WORD_W-1:0] mag_a;
    logic [WORD_W-1:0] mag_b;

    assign mag_a     = dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
    assign mag_b     = divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
    assign rem_shift = {rem_reg, quo_reg[WORD_W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        count_next = count_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        if (start)
        begin
            count_next = CNT_W'(DIV_STEPS);
            rem_next   = '0;
            quo_next   = mag_a;
            dvs_next   = mag_b;
            neg_q_next = dividend[WORD_W-1] ^ divisor[WORD_W-1];
            neg_r_next = dividend[WORD_W-1];
        end
        else if (count_reg != '0)
        begin
            // restore when the trial subtraction goes negative
            if (!diff[WORD_W])
            begin
                rem_next = diff[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            count_next = count_reg - CNT_W'(1);
            done_next  = (count_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            dvs_reg   <= dvs_next;
            neg_q_reg <= neg_q_next;
            neg_r_reg <= neg_r_next;
        end
    end

    assign result.done      = done_reg;
    assign result.quotient  = neg_q_reg ? (WORD_W'(0) - quo_reg) : quo_reg;
    assign result.remainder = neg_r_reg ? (WORD_W'(0) - rem_reg) : rem_reg;

endmodule

// ===== design/stack_alu_binary_ops.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_alu_binary_ops
// Reverse-Polish evaluation stack of signed words held in a row of shift
// cells, with push, add, sub, mul, div and mod, one response per request.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  req_t (req_type, push_value)
//   res       out        res_valid / res_stall  res_t (status, top_value,
//                                                      stack_depth)
//
// One request at a time. Push, add, sub, mul and unused codes go from S_IDLE
// through S_EXEC and S_DONE; div and mod also wait in S_DIV for the bit-serial
// divider (32 steps). Reset clears depth, halt and handshake state; the stack
// cells need none. A stalled response holds in the output register while the
// next request is already taken and worked on; it finishes once that slot frees.
// ----------------------------------------------------------------------------
module stack_alu_binary_ops
    import salu_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int EXT_W   = (DEPTH_W > DEPTH_OUT_W) ? DEPTH_W : DEPTH_OUT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DONE
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [2:0]         op_reg;
    logic [2:0]         op_next;
    logic [WORD_W-1:0]  val_reg;
    logic [WORD_W-1:0]  val_next;
    logic [WORD_W-1:0]  word_reg;
    logic [WORD_W-1:0]  word_next;
    logic [2:0]         status_reg;
    logic [2:0]         status_next;
    logic               push_reg;
    logic               push_next;
    logic               pop_reg;
    logic               pop_next;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic               halted_reg;
    logic               halted_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    res_t               out_reg;
    res_t               out_next;

    logic [WORD_W-1:0]  cell_q [STACK_DEPTH];
    cell_ctrl_t         cell_ctrl [STACK_DEPTH];
    logic [WORD_W-1:0]  top_word;
    logic [WORD_W-1:0]  sec_word;
    logic [WORD_W-1:0]  prod_lo;
    logic [WORD_W-1:0]  new_top;
    logic [DEPTH_W-1:0] depth_after;
    logic [EXT_W-1:0]   depth_ext;
    logic               out_free;
    logic               apply;
    logic               div_start;
    div_out_t           div_out;

    assign top_word = cell_q[0];
    assign sec_word = cell_q[1];
    assign prod_lo  = sec_word * top_word;
    assign out_free = !out_valid_reg || !res_stall;
    assign apply    = (state_reg == S_DONE) && out_free;

    // new top goes into cell 0; deeper cells shift toward it or away from it
    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            logic [WORD_W-1:0] above_w;
            logic [WORD_W-1:0] below_w;

            if (gi == 0)
            begin : g_head
                assign above_w = push_reg ? val_reg : word_reg;
            end
            else
            begin : g_body
                assign above_w = cell_q[gi-1];
            end

            if (gi == STACK_DEPTH - 1)
            begin : g_tail
                assign below_w = '0;
            end
            else
            begin : g_inner
                assign below_w = cell_q[gi+1];
            end

            assign cell_ctrl[gi].take_above = apply && (push_reg || (pop_reg && gi == 0));
            assign cell_ctrl[gi].take_below = apply && pop_reg && (gi != 0);

            salu_cell u_cell (
                .clk   (clk),
                .ctrl  (cell_ctrl[gi]),
                .above (above_w),
                .below (below_w),
                .value (cell_q[gi])
            );
        end
    endgenerate

    salu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sec_word),
        .divisor  (top_word),
        .result   (div_out)
    );

    always_comb
    begin
        unique case ({push_reg, pop_reg})
            2'b10:   depth_after = depth_reg + DEPTH_W'(1);
            2'b01:   depth_after = depth_reg - DEPTH_W'(1);
            default: depth_after = depth_reg;
        endcase
    end

    assign depth_ext = EXT_W'(depth_after);

    always_comb
    begin
        priority if (push_reg)
        begin
            new_top = val_reg;
        end
        else if (pop_reg)
        begin
            new_top = word_reg;
        end
        else if (depth_reg != '0)
        begin
            new_top = top_word;
        end
        else
        begin
            new_top = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        word_next      = word_reg;
        status_next    = status_reg;
        push_next      = push_reg;
        pop_next       = pop_reg;
        depth_next     = depth_reg;
        halted_next    = halted_reg;
        out_valid_next = out_valid_reg && res_stall;
        out_next       = out_reg;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.req_type;
                    val_next   = req.push_value;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = ST_OK;
                push_next   = 1'b0;
                pop_next    = 1'b0;
                state_next  = S_DONE;
                if (halted_reg)
                begin
                    status_next = ST_HALTED;
                end
                else
                begin
                    unique case (op_reg)
                        OP_PUSH:
                        begin
                            if (depth_reg == DEPTH_W'(STACK_DEPTH))
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                push_next = 1'b1;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
                        begin
                            if (depth_reg < DEPTH_W'(2))
                            begin
                                status_next = ST_SHORT;
                                halted_next = 1'b1;
                            end
                            else if ((op_reg == OP_DIV || op_reg == OP_MOD) &&
                                     top_word == '0)
                            begin
                                status_next = ST_DIVZERO;
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                pop_next = 1'b1;
                                unique case (op_reg)
                                    OP_ADD:  word_next = sec_word + top_word;
                                    OP_SUB:  word_next = sec_word - top_word;
                                    OP_MUL:  word_next = prod_lo;
                                    default:
                                    begin
                                        div_start  = 1'b1;
                                        state_next = S_DIV;
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_out.done)
                begin
                    word_next  = (op_reg == OP_DIV) ? div_out.quotient : div_out.remainder;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // wait for the response slot, then commit the stack update
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.status      = status_reg;
                    out_next.top_value   = new_top;
                    out_next.stack_depth = depth_ext[DEPTH_OUT_W-1:0];
                    depth_next           = depth_after;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            push_reg      <= 1'b0;
            pop_reg       <= 1'b0;
            depth_reg     <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            push_reg      <= push_next;
            pop_reg       <= pop_next;
            depth_reg     <= depth_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
            val_reg       <= val_next;
            word_reg      <= word_next;
            status_reg    <= status_next;
            out_reg       <= out_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// ===== design/salu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salu_checker
// Port-level checks of the stack ALU, bound to the top level.
// ----------------------------------------------------------------------------
module salu_checker
    import salu_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic res_valid,
    input logic res_stall,
    input res_t res
);

    // a stalled response holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled response changed");

    // one request at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    // an empty stack reports a zero top
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == ST_OK && res.stack_depth == '0 |->
            res.top_value == '0)
        else $error("empty stack with nonzero top");

    // overflow only on a full stack
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == ST_OVERFLOW |->
            res.stack_depth == DEPTH_OUT_W'(STACK_DEPTH))
        else $error("overflow reported below full depth");

    // too-short only with fewer than two entries
    a_short_depth: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == ST_SHORT |-> res.stack_depth < DEPTH_OUT_W'(2))
        else $error("too-short reported with two or more entries");

endmodule

bind stack_alu_binary_ops salu_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_salu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

// ===== verif/tb_stack_alu_binary_ops.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_alu_binary_ops
// Self-checking bench for the evaluation stack ALU. Requests are sent through
// the valid/stall channel with random gaps. Every accepted request is run
// through a local stack model, and each response is compared field by field
// with the oldest prediction. Covers arithmetic wrap, truncating divide and
// remainder, full-stack pushes, unused codes and one halting error at the end.
// ----------------------------------------------------------------------------
module tb_stack_alu_binary_ops;
    import salu_pkg::*;

    localparam int STACK_N        = DEFAULT_STACK_DEPTH;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1600;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;

    // stack model
    logic [WORD_W-1:0] model_stack [0:STACK_N-1];
    int                model_depth = 0;
    logic              model_halted = 1'b0;

    res_t predicted_responses [$];

    bit    quiet_run = 1'b0;
    int    fail_count = 0;
    int    n_accepted = 0;
    int    n_checked = 0;
    int    n_divmod = 0;
    int    n_overflow = 0;
    int    stall_left = 0;
    int    idle_cycles = 0;
    string halt_kind = "none";

    stack_alu_binary_ops #(
        .STACK_DEPTH(STACK_N)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] abs_word(input logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? (0 - v) : v;
    endfunction

    // truncate toward zero; the remainder follows the dividend's sign
    function automatic logic [WORD_W-1:0] quotient_trunc(input logic [WORD_W-1:0] a,
                                                         input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] q;
        q = abs_word(a) / abs_word(b);
        return (a[WORD_W-1] ^ b[WORD_W-1]) ? (0 - q) : q;
    endfunction

    function automatic logic [WORD_W-1:0] remainder_trunc(input logic [WORD_W-1:0] a,
                                                          input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] r;
        r = abs_word(a) % abs_word(b);
        return a[WORD_W-1] ? (0 - r) : r;
    endfunction

    function automatic res_t apply_stack_op(input req_t r);
        res_t              o;
        logic [WORD_W-1:0] top;
        logic [WORD_W-1:0] sec;
        logic [WORD_W-1:0] value;
        bit                div_ok;
        o.status = ST_OK;
        value = '0;
        div_ok = 1'b1;
        if (model_halted)
            o.status = ST_HALTED;
        else if (r.req_type == OP_PUSH)
        begin
            if (model_depth >= STACK_N)
            begin
                o.status = ST_OVERFLOW;
                n_overflow++;
            end
            else
            begin
                model_stack[model_depth] = r.push_value;
                model_depth++;
            end
        end
        else if (r.req_type <= OP_MOD)
        begin
            if (model_depth < 2)
            begin
                o.status = ST_SHORT;
                model_halted = 1'b1;
            end
            else
            begin
                top = model_stack[model_depth-1];
                sec = model_stack[model_depth-2];
                case (r.req_type)
                    OP_ADD: value = sec + top;
                    OP_SUB: value = sec - top;
                    OP_MUL: value = sec * top;
                    default:
                    begin
                        if (top == '0)
                            div_ok = 1'b0;
                        else if (r.req_type == OP_DIV)
                            value = quotient_trunc(sec, top);
                        else
                            value = remainder_trunc(sec, top);
                    end
                endcase
                if (div_ok)
                begin
                    model_stack[model_depth-2] = value;
                    model_depth--;
                end
                else
                begin
                    o.status = ST_DIVZERO;
                    model_halted = 1'b1;
                end
            end
        end
        o.top_value = (model_depth > 0) ? model_stack[model_depth-1] : '0;
        o.stack_depth = DEPTH_OUT_W'(model_depth);
        return o;
    endfunction

    // enter and leave at a rising edge; valid stays high after the accept
    task automatic send_request(input logic [2:0] op, input logic [WORD_W-1:0] value);
        req_t item;
        int   gap;
        item.req_type = op;
        item.push_value = value;
        gap = 0;
        if (!quiet_run && $urandom_range(99) < 15)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            req <= {3'($urandom), 32'($urandom)};
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (req_stall);
        predicted_responses.push_back(apply_stack_op(item));
        n_accepted++;
        if (op == OP_DIV || op == OP_MOD)
            n_divmod++;
    endtask

    // hold off the sender until every predicted response has arrived
    task automatic drain_responses();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (predicted_responses.size() != 0);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return $urandom;
        else if (sel < 70)
            return WORD_W'($signed($urandom_range(40)) - 20);
        else if (sel < 80)
        begin
            case ($urandom_range(4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                3: return 32'h0000_0001;
                default: return 32'h0000_0000;
            endcase
        end
        else
            return $urandom >> $urandom_range(31);
    endfunction

    function automatic logic [2:0] pick_binary_op();
        logic [2:0] op;
        op = 3'($urandom_range(OP_ADD, OP_MOD));
        // never let a random divide hit a zero divisor
        if ((op == OP_DIV || op == OP_MOD) && model_stack[model_depth-1] == '0)
            op = OP_SUB;
        return op;
    endfunction

    task automatic test_directed_arith();
        send_request(3'd6, 32'hDEAD_BEEF);
        send_request(OP_PUSH, 32'h7FFF_FFFF);
        send_request(OP_PUSH, 32'h0000_0001);
        send_request(OP_ADD, 32'hFFFF_FFFF);
        send_request(OP_PUSH, 32'hFFFF_FFFF);
        send_request(OP_DIV, 32'h0);
        send_request(OP_PUSH, 32'hFFFF_FFFF);
        send_request(OP_MOD, 32'h0);
        send_request(OP_PUSH, -32'sd7);
        send_request(OP_PUSH, 32'd2);
        send_request(OP_DIV, 32'h0);
        send_request(OP_PUSH, 32'd2);
        send_request(OP_MOD, 32'h0);
        send_request(OP_PUSH, 32'd7);
        send_request(OP_PUSH, -32'sd2);
        send_request(OP_MOD, 32'h0);
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_SUB, 32'h0);
        send_request(OP_PUSH, 32'h0001_0000);
        send_request(OP_PUSH, 32'h0001_0000);
        send_request(OP_MUL, 32'h0);
        send_request(OP_ADD, 32'h0);
        send_request(3'd7, 32'h1234_5678);
        send_request(OP_SUB, 32'hFFFF_FFFF);
    endtask

    task automatic test_full_stack();
        while (model_depth < STACK_N)
            send_request(OP_PUSH, pick_word());
        // both pushes must be dropped
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_PUSH, 32'h7FFF_FFFF);
        while (model_depth > 3)
            send_request(3'($urandom_range(OP_ADD, OP_SUB)), pick_word());
    endtask

    task automatic test_random_programs(input int n_items);
        int done;
        int push_pct;
        done = 0;
        push_pct = 50;
        while (done < n_items)
        begin
            quiet_run = (done >= 600 && done < 900);
            if (done == 1000)
                drain_responses();
            if (done % 50 == 0)
                push_pct = $urandom_range(20, 80);
            if ($urandom_range(99) < 3)
            begin
                // unused code: ignored by the block, not counted
                send_request(3'($urandom_range(6, 7)), $urandom);
                continue;
            end
            if (model_depth < 2)
                send_request(OP_PUSH, pick_word());
            else if (model_depth >= STACK_N)
            begin
                if ($urandom_range(99) < 30)
                    send_request(OP_PUSH, pick_word());
                else
                    send_request(pick_binary_op(), $urandom);
            end
            else if ($urandom_range(99) < push_pct)
                send_request(OP_PUSH, pick_word());
            else
                send_request(pick_binary_op(), $urandom);
            done++;
        end
        quiet_run = 1'b0;
    endtask

    // one error per run, since only reset clears the halt
    task automatic test_error_halt();
        if ($urandom_range(1) == 1)
        begin
            halt_kind = "divide-by-zero";
            // make room so the zero divisor is not dropped as an overflow
            while (model_depth >= STACK_N)
                send_request(OP_ADD, $urandom);
            if (model_depth == 0)
                send_request(OP_PUSH, pick_word());
            send_request(OP_PUSH, 32'h0);
            send_request($urandom_range(1) ? OP_DIV : OP_MOD, $urandom);
        end
        else
        begin
            halt_kind = "stack-too-short";
            while (model_depth >= 2)
                send_request(3'($urandom_range(OP_ADD, OP_SUB)), $urandom);
            send_request(3'($urandom_range(OP_ADD, OP_MOD)), $urandom);
        end
        repeat (10)
            send_request(3'($urandom_range(7)), $urandom);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_arith();
        test_full_stack();
        test_random_programs(RANDOM_ITEMS);
        test_error_halt();
        drain_responses();
        repeat (50) @(posedge clk);
        $display("Sent %0d requests (%0d div/mod, %0d overflow pushes), %0d responses checked.",
                 n_accepted, n_divmod, n_overflow, n_checked);
        $display("Run ended with a %s halt.", halt_kind);
        if (fail_count == 0)
            $display("** stack_alu_binary_ops: PASSED **");
        else
            $display("** stack_alu_binary_ops: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin : response_check
        res_t want;
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_valid && !res_stall)
            begin
                n_checked++;
                if (predicted_responses.size() == 0)
                begin
                    $error("unexpected response: status %0d top %0d depth %0d",
                           res.status, res.top_value, res.stack_depth);
                    fail_count++;
                end
                else
                begin
                    want = predicted_responses.pop_front();
                    if (res.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, res.status);
                        fail_count++;
                    end
                    if (res.top_value !== want.top_value)
                    begin
                        $error("top_value: expected %0d, got %0d",
                               want.top_value, res.top_value);
                        fail_count++;
                    end
                    if (res.stack_depth !== want.stack_depth)
                    begin
                        $error("stack_depth: expected %0d, got %0d",
                               want.stack_depth, res.stack_depth);
                        fail_count++;
                    end
                end
            end
            // stall in short bursts
            if (stall_left > 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else if (!quiet_run && $urandom_range(99) < 4)
            begin
                stall_left = $urandom_range(0, 5);
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("** stack_alu_binary_ops: FAILED **");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== filelist.f =====
design/salu_pkg.sv
design/salu_cell.sv
design/salu_div.sv
design/stack_alu_binary_ops.sv
design/salu_checker.sv
verif/tb_stack_alu_binary_ops.sv
